// ----- src/hgc_pkg.sv -----
// Shared constants, types and helper functions of the height gradient colorizer.
`default_nettype none

package hgc_pkg;

    // Sizes of the stop table and of the data path.
    localparam int MAX_STOPS     = 7;
    localparam int MIN_STOPS     = 2;
    localparam int NUM_STOP_REGS = 7;
    localparam int HEIGHT_BITS   = 16;
    localparam int IN_W          = 16;
    localparam int STOP_W        = 40;
    localparam int STOP_H_LSB    = 24;
    localparam int CHAN_W        = 8;
    localparam int NUM_CHAN      = 3;
    localparam int PIX_W         = NUM_CHAN * CHAN_W;
    localparam int COUNT_W       = 3;
    localparam int IDX_W         = $clog2(NUM_STOP_REGS);
    localparam int CFG_IDX_W     = $clog2(NUM_STOP_REGS + 1);

    // Fraction and divider layout.
    localparam int FRAC_BITS  = 16;
    localparam int DIV_STEP   = 2;
    localparam int DIV_STAGES = FRAC_BITS / DIV_STEP;
    localparam int DIFF_W     = CHAN_W + 1;
    localparam int PROD_W     = DIFF_W + FRAC_BITS + 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_FIRST = CFG_IDX_W'(1);

    // Reset values of the configuration.
    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(2);
    localparam logic [STOP_W-1:0]  STOP_RESET  = '0;
    localparam logic [STOP_W-1:0]  STOP1_RESET = '1;

    typedef logic [HEIGHT_BITS-1:0]                t_height;
    typedef logic [STOP_W-1:0]                     t_stop;
    typedef logic [NUM_STOP_REGS-1:0][STOP_W-1:0]  t_stop_arr;
    typedef logic [IDX_W-1:0]                      t_idx;
    typedef logic [FRAC_BITS-1:0]                  t_frac;
    // Pixel with red in element 0, green in 1, blue in 2.
    typedef logic [NUM_CHAN-1:0][CHAN_W-1:0]       t_pix;

    // Pair of stops that bound the selected segment.
    typedef struct packed {
        t_idx lo;
        t_idx hi;
    } t_seg_sel;

    // Height field of a stop register.
    function automatic t_height stop_height(input t_stop s);
        stop_height = s[STOP_H_LSB +: HEIGHT_BITS];
    endfunction

    // Colour of a stop register, red in the lowest element.
    function automatic t_pix stop_color(input t_stop s);
        t_pix c;
        c[0] = s[2*CHAN_W +: CHAN_W];
        c[1] = s[CHAN_W +: CHAN_W];
        c[2] = s[0 +: CHAN_W];
        stop_color = c;
    endfunction

endpackage

`default_nettype wire

// ----- src/height_gradient_colorizer.sv -----
// Top level of the height gradient colorizer: configuration, pipeline and output buffer.
//
//  Channel   Direction  Payload (lowest bit first)               Handshake
//  s_axis    in         tdata[15:0] height                       tvalid / tready
//  m_axis    out        tdata[7:0] red, [15:8] green, [23:16] blue  tvalid / tready
//  cfg       in         i_cfg_idx register, i_cfg_data value     i_cfg_we
//
// One height is taken per cycle while s_axis_tready is high; the pixel for it passes
// 3 clamp and search stages, 8 divider stages, 3 blend stages and 1 output register.
// The divider resolves two fraction bits per stage, which sets the depth.
// Reset empties the pipeline and restores the default two-stop ramp.
// A stalled output holds in the output register; one more request goes into a
// skid register, and only then does the pipeline freeze and tready drop.
`default_nettype none

module height_gradient_colorizer (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    // Height samples.
    input  wire                           s_axis_tvalid,
    output logic                          s_axis_tready,
    input  wire [hgc_pkg::IN_W-1:0]       s_axis_tdata,   // [15:0] height
    // Colored pixels.
    output logic                          m_axis_tvalid,
    input  wire                           m_axis_tready,
    output logic [hgc_pkg::PIX_W-1:0]     m_axis_tdata,   // [7:0] red, [15:8] green, [23:16] blue
    // Configuration writes.
    input  wire                           i_cfg_we,
    input  wire [hgc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [hgc_pkg::STOP_W-1:0]     i_cfg_data
);

    logic [hgc_pkg::COUNT_W-1:0] r_count;
    hgc_pkg::t_stop_arr          r_stops;
    logic [hgc_pkg::COUNT_W-1:0] eff_count;
    hgc_pkg::t_idx               last_idx;
    logic                        ce;

    logic              seg_v, div_v, lerp_v;
    hgc_pkg::t_height  seg_num, seg_den;
    hgc_pkg::t_seg_sel seg_sel, div_sel;
    hgc_pkg::t_frac    div_frac;
    hgc_pkg::t_pix     lerp_pix;

    logic          r_out_v, r_skid_v;
    hgc_pkg::t_pix r_out_pix, r_skid_pix;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= hgc_pkg::COUNT_RESET;
            for (int k = 0; k < hgc_pkg::NUM_STOP_REGS; k++) begin
                r_stops[k] <= (k == 1) ? hgc_pkg::STOP1_RESET : hgc_pkg::STOP_RESET;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_idx == hgc_pkg::CFG_STOP_COUNT) begin
                r_count <= i_cfg_data[hgc_pkg::COUNT_W-1:0];
            end else if (i_cfg_idx >= hgc_pkg::CFG_STOP_FIRST) begin
                r_stops[hgc_pkg::IDX_W'(i_cfg_idx - hgc_pkg::CFG_STOP_FIRST)] <= i_cfg_data;
            end
        end
    end

    // Stop count in use, held between two and the maximum.
    always_comb begin
        if (r_count < hgc_pkg::COUNT_W'(hgc_pkg::MIN_STOPS)) begin
            eff_count = hgc_pkg::COUNT_W'(hgc_pkg::MIN_STOPS);
        end else if (r_count > hgc_pkg::COUNT_W'(hgc_pkg::MAX_STOPS)) begin
            eff_count = hgc_pkg::COUNT_W'(hgc_pkg::MAX_STOPS);
        end else begin
            eff_count = r_count;
        end
        last_idx = hgc_pkg::IDX_W'(eff_count - hgc_pkg::COUNT_W'(1));
    end

    // The pipeline advances unless the skid register is holding a pixel.
    assign ce            = !r_skid_v;
    assign s_axis_tready = ce;

    hgc_seg u_seg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ce       (ce),
        .i_valid    (s_axis_tvalid),
        .i_height   (s_axis_tdata),
        .i_stops    (r_stops),
        .i_last_idx (last_idx),
        .o_valid    (seg_v),
        .o_num      (seg_num),
        .o_den      (seg_den),
        .o_sel      (seg_sel)
    );

    hgc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (seg_v),
        .i_num   (seg_num),
        .i_den   (seg_den),
        .i_sel   (seg_sel),
        .o_valid (div_v),
        .o_frac  (div_frac),
        .o_sel   (div_sel)
    );

    hgc_lerp u_lerp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (div_v),
        .i_frac  (div_frac),
        .i_sel   (div_sel),
        .i_stops (r_stops),
        .o_valid (lerp_v),
        .o_pix   (lerp_pix)
    );

    // Output register and skid register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (m_axis_tready) begin
                r_skid_v <= 1'b0;
            end
        end else if (!r_out_v || m_axis_tready) begin
            r_out_v <= lerp_v;
        end else if (lerp_v) begin
            r_skid_v <= 1'b1;
        end
    end

    // Output register and skid register payload.
    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (m_axis_tready) begin
                r_out_pix <= r_skid_pix;
            end
        end else if (!r_out_v || m_axis_tready) begin
            r_out_pix <= lerp_pix;
        end else begin
            r_skid_pix <= lerp_pix;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out_pix;

endmodule

`default_nettype wire

// ----- src/hgc_seg.sv -----
// Clamp of the height and search for the gradient segment that holds it.
`default_nettype none

module hgc_seg (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_ce,
    input  wire                  i_valid,
    input  wire [hgc_pkg::IN_W-1:0] i_height,
    input  hgc_pkg::t_stop_arr   i_stops,
    input  hgc_pkg::t_idx        i_last_idx,
    output logic                 o_valid,
    output hgc_pkg::t_height     o_num,
    output hgc_pkg::t_height     o_den,
    output hgc_pkg::t_seg_sel    o_sel
);

    localparam int NSEG = hgc_pkg::NUM_STOP_REGS - 1;

    hgc_pkg::t_height heights [hgc_pkg::NUM_STOP_REGS];

    logic             r_a_v, r_b_v, r_c_v;
    hgc_pkg::t_height r_a_h, n_a_h;
    hgc_pkg::t_height r_b_h;
    logic [NSEG-1:0]  r_b_hit, n_b_hit;
    hgc_pkg::t_height r_c_num, n_c_num;
    hgc_pkg::t_height r_c_den, n_c_den;
    hgc_pkg::t_seg_sel r_c_sel, n_c_sel;

    // Stop heights taken out of the stop registers.
    always_comb begin
        for (int k = 0; k < hgc_pkg::NUM_STOP_REGS; k++) begin
            heights[k] = hgc_pkg::stop_height(i_stops[k]);
        end
    end

    // Stage A: clamp to the first and last stop heights.
    always_comb begin
        hgc_pkg::t_height h;
        hgc_pkg::t_height top;
        h   = i_height[hgc_pkg::HEIGHT_BITS-1:0];
        top = heights[i_last_idx];
        if (h < heights[0]) begin
            h = heights[0];
        end
        if (h > top) begin
            h = top;
        end
        n_a_h = h;
    end

    // Stage B: one compare pair per segment in use.
    always_comb begin
        for (int j = 0; j < NSEG; j++) begin
            n_b_hit[j] = (hgc_pkg::IDX_W'(j) < i_last_idx) &&
                         (r_a_h >= heights[j]) && (r_a_h < heights[j+1]);
        end
    end

    // Stage C: the first hit wins; with no hit both bounds are the last stop.
    always_comb begin
        hgc_pkg::t_idx lo;
        hgc_pkg::t_idx hi;
        lo = i_last_idx;
        hi = i_last_idx;
        for (int j = NSEG - 1; j >= 0; j--) begin
            if (r_b_hit[j]) begin
                lo = hgc_pkg::IDX_W'(j);
                hi = hgc_pkg::IDX_W'(j + 1);
            end
        end
        n_c_sel.lo = lo;
        n_c_sel.hi = hi;
        n_c_num    = r_b_h - heights[lo];
        n_c_den    = heights[hi] - heights[lo];
    end

    // Valid bits of the three stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
        end else if (i_ce) begin
            r_a_v <= i_valid;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
        end
    end

    // Payload of the three stages.
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_a_h   <= n_a_h;
            r_b_h   <= r_a_h;
            r_b_hit <= n_b_hit;
            r_c_num <= n_c_num;
            r_c_den <= n_c_den;
            r_c_sel <= n_c_sel;
        end
    end

    assign o_valid = r_c_v;
    assign o_num   = r_c_num;
    assign o_den   = r_c_den;
    assign o_sel   = r_c_sel;

endmodule

`default_nettype wire

// ----- src/hgc_div.sv -----
// Pipelined restoring divider that forms the segment fraction, two bits a stage.
`default_nettype none

module hgc_div (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_ce,
    input  wire                  i_valid,
    input  hgc_pkg::t_height     i_num,
    input  hgc_pkg::t_height     i_den,
    input  hgc_pkg::t_seg_sel    i_sel,
    output logic                 o_valid,
    output hgc_pkg::t_frac       o_frac,
    output hgc_pkg::t_seg_sel    o_sel
);

    localparam int NS = hgc_pkg::DIV_STAGES;
    localparam int HB = hgc_pkg::HEIGHT_BITS;

    logic [NS-1:0]     r_v;
    hgc_pkg::t_height  r_rem [NS];
    hgc_pkg::t_height  n_rem [NS];
    hgc_pkg::t_height  r_den [NS];
    hgc_pkg::t_frac    r_q   [NS];
    hgc_pkg::t_frac    n_q   [NS];
    hgc_pkg::t_seg_sel r_sel [NS];

    // Each stage shifts the remainder and subtracts the divisor where it fits.
    // In a found segment the numerator is below the divisor, so the quotient fits the fraction.
    always_comb begin
        logic [HB:0]      rem2;
        hgc_pkg::t_height rem;
        hgc_pkg::t_height den;
        hgc_pkg::t_frac   q;
        for (int s = 0; s < NS; s++) begin
            if (s == 0) begin
                rem = i_num;
                den = i_den;
                q   = '0;
            end else begin
                rem = r_rem[s-1];
                den = r_den[s-1];
                q   = r_q[s-1];
            end
            for (int b = 0; b < hgc_pkg::DIV_STEP; b++) begin
                rem2 = {rem, 1'b0};
                if (rem2 >= {1'b0, den}) begin
                    rem2 = rem2 - {1'b0, den};
                    q    = {q[hgc_pkg::FRAC_BITS-2:0], 1'b1};
                end else begin
                    q    = {q[hgc_pkg::FRAC_BITS-2:0], 1'b0};
                end
                rem = rem2[HB-1:0];
            end
            n_rem[s] = rem;
            n_q[s]   = q;
        end
    end

    // Valid bits travel with the stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_ce) begin
            r_v <= {r_v[NS-2:0], i_valid};
        end
    end

    // Remainder, divisor, partial quotient and segment bounds.
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            for (int s = 0; s < NS; s++) begin
                r_rem[s] <= n_rem[s];
                r_q[s]   <= n_q[s];
                if (s == 0) begin
                    r_den[s] <= i_den;
                    r_sel[s] <= i_sel;
                end else begin
                    r_den[s] <= r_den[s-1];
                    r_sel[s] <= r_sel[s-1];
                end
            end
        end
    end

    assign o_valid = r_v[NS-1];
    assign o_frac  = r_q[NS-1];
    assign o_sel   = r_sel[NS-1];

endmodule

`default_nettype wire

// ----- src/hgc_lerp.sv -----
// Linear blend of the two segment colours by the fraction, in three stages.
`default_nettype none

module hgc_lerp (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_ce,
    input  wire                  i_valid,
    input  hgc_pkg::t_frac       i_frac,
    input  hgc_pkg::t_seg_sel    i_sel,
    input  hgc_pkg::t_stop_arr   i_stops,
    output logic                 o_valid,
    output hgc_pkg::t_pix        o_pix
);

    localparam int NC = hgc_pkg::NUM_CHAN;
    localparam int CW = hgc_pkg::CHAN_W;
    localparam int DW = hgc_pkg::DIFF_W;
    localparam int PW = hgc_pkg::PROD_W;
    localparam int FB = hgc_pkg::FRAC_BITS;

    logic                 r1_v, r2_v, r3_v;
    hgc_pkg::t_pix        r1_c0, r2_c0;
    hgc_pkg::t_frac       r1_f;
    logic signed [DW-1:0] r1_diff [NC];
    logic signed [DW-1:0] n1_diff [NC];
    logic signed [PW-1:0] r2_prod [NC];
    logic signed [PW-1:0] n2_prod [NC];
    hgc_pkg::t_pix        r3_pix, n3_pix;
    hgc_pkg::t_pix        c0, c1;

    // Stage 1: fetch both colours and form the channel differences.
    always_comb begin
        c0 = hgc_pkg::stop_color(i_stops[i_sel.lo]);
        c1 = hgc_pkg::stop_color(i_stops[i_sel.hi]);
        for (int ch = 0; ch < NC; ch++) begin
            n1_diff[ch] = $signed({1'b0, c1[ch]}) - $signed({1'b0, c0[ch]});
        end
    end

    // Stage 2: signed difference times the unsigned fraction.
    always_comb begin
        logic signed [PW-1:0] d;
        logic signed [PW-1:0] f;
        for (int ch = 0; ch < NC; ch++) begin
            d = PW'(r1_diff[ch]);
            f = $signed({{(PW-FB){1'b0}}, r1_f});
            n2_prod[ch] = d * f;
        end
    end

    // Stage 3: add the base colour and drop the fraction bits.
    // The sum never goes negative, since the fraction stays below one.
    always_comb begin
        logic signed [PW-1:0] total;
        for (int ch = 0; ch < NC; ch++) begin
            total = $signed({{(PW-CW-FB){1'b0}}, r2_c0[ch], {FB{1'b0}}}) + r2_prod[ch];
            n3_pix[ch] = total[FB +: CW];
        end
    end

    // Valid bits of the three stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (i_ce) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    // Payload of the three stages.
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r1_c0  <= c0;
            r1_f   <= i_frac;
            r1_diff <= n1_diff;
            r2_c0  <= r1_c0;
            r2_prod <= n2_prod;
            r3_pix <= n3_pix;
        end
    end

    assign o_valid = r3_v;
    assign o_pix   = r3_pix;

endmodule

`default_nettype wire
